>>> sv/arpc_pkg.sv
// Shared types and constants for the ARP cache lookup and learn core.
`timescale 1ns / 1ps

package arpc_pkg;

    localparam int ENTRIES = 8;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int IP_W    = 32;
    localparam int MAC_W   = 48;
    localparam int ENTRY_W = IP_W + MAC_W;

    typedef logic [IDX_W-1:0] t_idx;

    localparam t_idx LAST_IDX = t_idx'(ENTRIES - 1);

    localparam logic FUNC_LOOKUP = 1'b0;
    localparam logic FUNC_LEARN  = 1'b1;

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_UPDATED = 2'd1,
        ACT_FILLED  = 2'd2,
        ACT_EVICTED = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } t_state;

endpackage

>>> sv/arpc_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/arp_cache_lookup_learn_core.sv
// ARP cache core: sequential scan of the entry table for lookup and learn items.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------------
//  command | in        | start high, busy low | i_func, i_ip_address, i_mac_address
//  result  | out       | o_valid, one cycle   | o_hit, o_found_mac, o_learn_action
//
// An item is accepted in ST_IDLE, scanned in ST_SCAN and answered in ST_RESP; the
// core then returns to ST_IDLE for the next item. A match ends the scan early. The
// entry RAM is read one entry a cycle with a registered read port, and its single
// compare unit, which checks the entries in turn, sets that rate. An ignored learn
// skips the scan and goes straight to the result. Reset clears the valid bits and
// the replacement pointer at once. Results cannot be stalled; busy stays high until
// the result cycle ends.
`timescale 1ns / 1ps

module arp_cache_lookup_learn_core
    import arpc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic             i_func,
    input  logic [IP_W-1:0]  i_ip_address,
    input  logic [MAC_W-1:0] i_mac_address,
    output logic             o_valid,
    output logic             o_hit,
    output logic [MAC_W-1:0] o_found_mac,
    output logic [1:0]       o_learn_action
);

    // control state
    t_state             r_state,     n_state;
    logic [ENTRIES-1:0] r_valid,     n_valid;
    t_idx               r_ptr,       n_ptr;
    t_idx               r_idx,       n_idx;
    t_idx               r_cmp_idx,   n_cmp_idx;
    logic               r_cmp_vld,   n_cmp_vld;
    logic               r_free_seen, n_free_seen;

    // payload
    logic               r_func,      n_func;
    logic [IP_W-1:0]    r_ip,        n_ip;
    logic [MAC_W-1:0]   r_mac,       n_mac;
    t_idx               r_free_idx,  n_free_idx;
    logic               r_hit,       n_hit;
    logic [MAC_W-1:0]   r_found,     n_found;
    t_action            r_action,    n_action;

    // RAM port
    logic               ram_we;
    t_idx               ram_waddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [IP_W-1:0]    rd_ip;
    logic [MAC_W-1:0]   rd_mac;
    logic               accept;
    logic               ignore;
    logic               match;

    arpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({r_ip, r_mac}),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    assign rd_ip  = ram_rdata[ENTRY_W-1:MAC_W];
    assign rd_mac = ram_rdata[MAC_W-1:0];

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign ignore = (i_func == FUNC_LEARN) &&
                    ((i_ip_address == '0) || (i_mac_address == '0) ||
                     (i_mac_address == '1));
    assign match  = r_cmp_vld && r_valid[r_cmp_idx] && (rd_ip == r_ip);

    always_comb begin
        n_state     = r_state;
        n_valid     = r_valid;
        n_ptr       = r_ptr;
        n_idx       = r_idx;
        n_cmp_idx   = r_cmp_idx;
        n_cmp_vld   = r_cmp_vld;
        n_free_seen = r_free_seen;
        n_func      = r_func;
        n_ip        = r_ip;
        n_mac       = r_mac;
        n_free_idx  = r_free_idx;
        n_hit       = r_hit;
        n_found     = r_found;
        n_action    = r_action;
        ram_we      = 1'b0;
        ram_waddr   = r_cmp_idx;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_func      = i_func;
                    n_ip        = i_ip_address;
                    n_mac       = i_mac_address;
                    n_hit       = 1'b0;
                    n_found     = '0;
                    n_action    = ACT_NONE;
                    n_idx       = '0;
                    n_cmp_vld   = 1'b0;
                    n_free_seen = 1'b0;
                    n_state     = ignore ? ST_RESP : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (match) begin
                    if (r_func == FUNC_LOOKUP) begin
                        n_hit   = 1'b1;
                        n_found = rd_mac;
                    end else begin
                        ram_we   = 1'b1;
                        n_action = ACT_UPDATED;
                    end
                    n_state = ST_RESP;
                end else if (r_cmp_vld && (r_cmp_idx == LAST_IDX)) begin
                    // no match anywhere: fill the lowest free entry, else evict
                    if (r_func == FUNC_LEARN) begin
                        ram_we = 1'b1;
                        if (r_free_seen || !r_valid[r_cmp_idx]) begin
                            ram_waddr = r_free_seen ? r_free_idx : r_cmp_idx;
                            n_action  = ACT_FILLED;
                        end else begin
                            ram_waddr = r_ptr;
                            n_action  = ACT_EVICTED;
                            n_ptr     = (r_ptr == LAST_IDX) ? '0 : r_ptr + t_idx'(1);
                        end
                        n_valid[ram_waddr] = 1'b1;
                    end
                    n_state = ST_RESP;
                end else begin
                    if (r_cmp_vld && !r_valid[r_cmp_idx] && !r_free_seen) begin
                        n_free_seen = 1'b1;
                        n_free_idx  = r_cmp_idx;
                    end
                    // advance the read address; the compare works on the address presented in the previous cycle
                    n_cmp_idx = r_idx;
                    n_cmp_vld = 1'b1;
                    n_idx     = r_idx + t_idx'(1);
                end
            end
            ST_RESP: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_ptr       <= '0;
            r_idx       <= '0;
            r_cmp_idx   <= '0;
            r_cmp_vld   <= 1'b0;
            r_free_seen <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_ptr       <= n_ptr;
            r_idx       <= n_idx;
            r_cmp_idx   <= n_cmp_idx;
            r_cmp_vld   <= n_cmp_vld;
            r_free_seen <= n_free_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_ip       <= n_ip;
        r_mac      <= n_mac;
        r_free_idx <= n_free_idx;
        r_hit      <= n_hit;
        r_found    <= n_found;
        r_action   <= n_action;
    end

    assign o_valid        = (r_state == ST_RESP);
    assign o_hit          = r_hit;
    assign o_found_mac    = r_found;
    assign o_learn_action = r_action;

endmodule
